/* sv/armu_pkg.sv */
package armu_pkg;

  // Memory geometry: eight byte lanes, one row of each lane per 64-bit word.
  localparam int MEM_BYTES = 4096;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROW_W     = ADDR_W - LANE_W;
  localparam int BANK_ROWS = MEM_BYTES / LANES;
  // Width of the unwrapped byte address sum (offset plus scaled index).
  localparam int SUM_W     = (ADDR_W > 16) ? ADDR_W : 16;

  typedef enum logic [3:0] {
    OP_LOAD    = 4'd0,
    OP_STORE   = 4'd1,
    OP_ADD     = 4'd2,
    OP_SUB     = 4'd3,
    OP_AND     = 4'd4,
    OP_OR      = 4'd5,
    OP_XOR     = 4'd6,
    OP_XCHG    = 4'd7,
    OP_CMPXCHG = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    CFG_VIEW_KIND   = 2'd0,
    CFG_VIEW_OFFSET = 2'd1,
    CFG_VIEW_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [11:0] elem_index;
    logic [63:0] operand_value;
    logic [63:0] expected_value;
  } req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        status;
  } rsp_t;

  // Mask for an element of 1, 2, 4 or 8 bytes, selected by log2 of the width.
  function automatic logic [63:0] width_mask(input logic [1:0] log_width);
    logic [63:0] m;
    case (log_width)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* sv/atomic_rmw_memory_unit_top.sv */
// Atomic read-modify-write unit over a byte memory held in eight byte-wide banks.
// Flow: an accepted start registers the request and reads the banks; in the execute
// state the new element is written back and the result is registered under done.
// busy stays high while executing, so a new request waits until the last is through.
// Reset (rst, synchronous) starts a clearing pass over all MEM_BYTES/8 rows (512 here)
// with busy high; configuration writes are taken at all times.
// Each result is shown for one cycle under done; the receiver cannot stall.
module atomic_rmw_memory_unit_top
  import armu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  // View configuration.
  logic [2:0]  view_kind;
  logic [11:0] view_byte_offset;
  logic [12:0] view_length;

  state_t state, state_next;
  logic   accept, clearing, executing;

  logic [ROW_W-1:0] clr_row;

  // Request captured at accept.
  req_t              req_q;
  logic [LANE_W-1:0] lane0;
  logic [ROW_W-1:0]  row_q [LANES];

  // Address path.
  logic [SUM_W-1:0]  scaled_index, addr_sum;
  logic [ADDR_W-1:0] base_addr;
  logic [ROW_W-1:0]  row0, row1;
  logic [ROW_W-1:0]  rd_row [LANES];

  // Bank ports.
  logic [7:0]       mem [LANES][BANK_ROWS];
  logic [7:0]       rd_data [LANES];
  logic             bank_we [LANES];
  logic [ROW_W-1:0] bank_wrow [LANES];
  logic [7:0]       bank_wdata [LANES];
  logic             lane_we [LANES];
  logic [7:0]       lane_wdata [LANES];

  // Execute-stage values.
  logic [1:0]  log_width;
  logic [3:0]  width_bytes;
  logic [63:0] mask, old_raw, old_val, new_val, new_masked, ext_val;
  logic        sign_bit, is_signed, in_range, write_op, do_write;
  rsp_t        rsp_next;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      view_kind        <= 3'd1;
      view_byte_offset <= '0;
      view_length      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VIEW_KIND:   view_kind        <= cfg_data[2:0];
        CFG_VIEW_OFFSET: view_byte_offset <= cfg_data[11:0];
        CFG_VIEW_LENGTH: view_length      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_row == {ROW_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    busy      = 1'b1;
    clearing  = 1'b0;
    executing = 1'b0;
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_EXEC:  executing = 1'b1;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_row <= clr_row + 1'b1;
    end
  end

  // Byte address of the first byte; the element may straddle two rows.
  always_comb begin
    scaled_index = SUM_W'(request.elem_index) << view_kind[2:1];
    addr_sum     = SUM_W'(view_byte_offset) + scaled_index;
    base_addr    = addr_sum[ADDR_W-1:0];
    row0         = base_addr[ADDR_W-1:LANE_W];
    row1         = row0 + 1'b1;
    for (int b = 0; b < LANES; b++) begin
      rd_row[b] = (LANE_W'(b) >= base_addr[LANE_W-1:0]) ? row0 : row1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
      lane0 <= base_addr[LANE_W-1:0];
      for (int b = 0; b < LANES; b++) row_q[b] <= rd_row[b];
    end
  end

  // Gather the old element from the lanes and compute the new one.
  always_comb begin
    log_width   = view_kind[2:1];
    is_signed   = !view_kind[0];
    width_bytes = 4'd1 << log_width;
    mask        = width_mask(log_width);
    for (int k = 0; k < LANES; k++) begin
      old_raw[8*k +: 8] = rd_data[lane0 + LANE_W'(k)];
    end
    old_val = old_raw & mask;

    case (req_q.operation)
      OP_STORE:   new_val = req_q.operand_value;
      OP_ADD:     new_val = old_val + req_q.operand_value;
      OP_SUB:     new_val = old_val - req_q.operand_value;
      OP_AND:     new_val = old_val & req_q.operand_value;
      OP_OR:      new_val = old_val | req_q.operand_value;
      OP_XOR:     new_val = old_val ^ req_q.operand_value;
      OP_XCHG:    new_val = req_q.operand_value;
      OP_CMPXCHG: new_val = (old_val == (req_q.expected_value & mask)) ?
                            req_q.operand_value : old_val;
      default:    new_val = old_val;
    endcase
    new_masked = new_val & mask;

    case (log_width)
      2'd0:    sign_bit = old_val[7];
      2'd1:    sign_bit = old_val[15];
      2'd2:    sign_bit = old_val[31];
      default: sign_bit = 1'b0;
    endcase
    ext_val = (is_signed && sign_bit) ? (old_val | ~mask) : old_val;

    in_range = {1'b0, req_q.elem_index} < view_length;
    write_op = req_q.operation inside {[OP_STORE:OP_CMPXCHG]};
    do_write = executing && in_range && write_op;

    // Scatter the new element back over the lanes it covers.
    for (int b = 0; b < LANES; b++) begin
      logic [LANE_W-1:0] k;
      k             = LANE_W'(b) - lane0;
      lane_wdata[b] = new_masked[{k, 3'b000} +: 8];
      lane_we[b]    = do_write && (4'(k) < width_bytes);
    end

    // Result: range error first, then store echo, then the old element; unused codes give zero.
    rsp_next.status     = 1'b0;
    rsp_next.read_value = '0;
    if (!in_range) begin
      rsp_next.status = 1'b1;
    end else if (req_q.operation == OP_STORE) begin
      rsp_next.read_value = req_q.operand_value;
    end else if (req_q.operation inside {[OP_LOAD:OP_CMPXCHG]}) begin
      rsp_next.read_value = ext_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= executing;
  end

  always_ff @(posedge clk) begin
    if (executing) result <= rsp_next;
  end

  // Bank write mux: the clearing pass zeroes one row of every bank per cycle.
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_we[b]    = clearing || lane_we[b];
      bank_wrow[b]  = clearing ? clr_row : row_q[b];
      bank_wdata[b] = clearing ? 8'h00 : lane_wdata[b];
    end
  end

  // Byte banks with one write and one registered read port each.
  always_ff @(posedge clk) begin
    for (int b = 0; b < LANES; b++) begin
      if (bank_we[b]) mem[b][bank_wrow[b]] <= bank_wdata[b];
      rd_data[b] <= mem[b][rd_row[b]];
    end
  end

endmodule

/* tb/armu_checker.sv */
`timescale 1ns / 100ps

// Watches the request, result and register channels of the atomic unit,
// keeps its own image of the byte memory and the view, and checks every result.
module armu_checker
  import armu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        request,
  input  logic        done,
  input  rsp_t        result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          pending,
  output int          failures,
  output int          checked,
  output int          swaps,
  output int          range_hits
);

  localparam logic       STATUS_DONE  = 1'b0;
  localparam logic       STATUS_RANGE = 1'b1;
  localparam logic [2:0] KIND_UINT8   = 3'd1;

  // Shadow of the memory and of the view registers.
  logic [7:0]  mem_img [MEM_BYTES];
  logic [2:0]  kind_cfg;
  logic [11:0] offset_cfg;
  logic [12:0] length_cfg;

  rsp_t awaited_results [$];
  int   fail_cnt;
  int   check_cnt;
  int   swap_cnt;
  int   range_cnt;

  // Little-endian element read; every byte address wraps around the memory.
  function automatic logic [63:0] read_elem(int unsigned base, int unsigned nbytes);
    logic [63:0] v;
    v = '0;
    for (int unsigned k = 0; k < nbytes; k++)
      v |= 64'(mem_img[(base + k) % MEM_BYTES]) << (8 * k);
    return v;
  endfunction

  function automatic void write_elem(int unsigned base, int unsigned nbytes, logic [63:0] v);
    for (int unsigned k = 0; k < nbytes; k++)
      mem_img[(base + k) % MEM_BYTES] = v[8*k +: 8];
  endfunction

  // Performs one request on the shadow memory and returns the result it must give.
  function automatic rsp_t apply_atomic(req_t rq);
    rsp_t        r;
    logic [1:0]  lw;
    int unsigned nbytes;
    int unsigned base;
    logic [63:0] msk;
    logic [63:0] old;
    logic [63:0] nv;
    lw     = kind_cfg[2:1];
    nbytes = 1 << lw;
    msk    = (lw == 2'd3) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
    r.read_value = '0;
    r.status     = STATUS_DONE;
    if (rq.elem_index >= length_cfg) begin
      r.status = STATUS_RANGE;
      range_cnt++;
      return r;
    end
    // Unused operation codes touch nothing.
    if (rq.operation > OP_CMPXCHG)
      return r;
    base = offset_cfg + rq.elem_index * nbytes;
    // A store echoes its operand as given.
    if (rq.operation == OP_STORE) begin
      write_elem(base, nbytes, rq.operand_value & msk);
      r.read_value = rq.operand_value;
      return r;
    end
    old = read_elem(base, nbytes);
    case (op_t'(rq.operation))
      OP_ADD:  nv = old + rq.operand_value;
      OP_SUB:  nv = old - rq.operand_value;
      OP_AND:  nv = old & rq.operand_value;
      OP_OR:   nv = old | rq.operand_value;
      OP_XOR:  nv = old ^ rq.operand_value;
      OP_XCHG: nv = rq.operand_value;
      OP_CMPXCHG: begin
        if (old == (rq.expected_value & msk)) begin
          nv = rq.operand_value;
          swap_cnt++;
        end else begin
          nv = old;
        end
      end
      default: nv = old;
    endcase
    if (rq.operation != OP_LOAD)
      write_elem(base, nbytes, nv & msk);
    // Extend the old element by the view's signedness.
    if (!kind_cfg[0] && lw != 2'd3 && old[8*nbytes-1])
      r.read_value = old | ~msk;
    else
      r.read_value = old;
    return r;
  endfunction

  // All channels are sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < MEM_BYTES; i++)
        mem_img[i] = 8'h00;
      kind_cfg   = KIND_UINT8;
      offset_cfg = '0;
      length_cfg = '0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_VIEW_KIND:   kind_cfg   = cfg_data[2:0];
          CFG_VIEW_OFFSET: offset_cfg = cfg_data[11:0];
          CFG_VIEW_LENGTH: length_cfg = cfg_data;
          default: ;
        endcase
      end
      // Compare a returned result with the oldest one awaited.
      if (done) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: value %h status %b", $time,
                   result.read_value, result.status);
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_cnt++;
          if (result.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h", $time,
                     want.read_value, result.read_value);
            fail_cnt++;
          end
          if (result.status !== want.status) begin
            $display("%0t: status mismatch: expected %b, actual %b", $time,
                     want.status, result.status);
            fail_cnt++;
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_atomic(request));
    end
    pending    <= awaited_results.size();
    failures   <= fail_cnt;
    checked    <= check_cnt;
    swaps      <= swap_cnt;
    range_hits <= range_cnt;
  end

  initial begin
    fail_cnt  = 0;
    check_cnt = 0;
    swap_cnt  = 0;
    range_cnt = 0;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import armu_pkg::*;

  localparam logic [3:0] OP_LAST_CODE = 4'hF;
  localparam logic [2:0] KIND_INT8    = 3'd0;
  localparam logic [2:0] KIND_INT16   = 3'd2;
  localparam logic [2:0] KIND_UINT64  = 3'd7;
  localparam int         PHASES       = 12;
  localparam int         PHASE_ITEMS  = 110;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        request = '0;
  logic        done;
  rsp_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  int          pending;
  int          failures;
  int          checked;
  int          swaps;
  int          range_hits;

  int unsigned idle_pct;
  int          items_sent;
  int          views;
  logic [63:0] last_put [16];

  atomic_rmw_memory_unit_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  armu_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .failures   (failures),
    .checked    (checked),
    .swaps      (swaps),
    .range_hits (range_hits)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Writes all three view registers back to back, then drops the valid.
  task automatic set_view(logic [2:0] kind, logic [11:0] offset, logic [12:0] length);
    logic [12:0] vals [3];
    vals[0] = 13'(kind);
    vals[1] = 13'(offset);
    vals[2] = length;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    views++;
  endtask

  // Issues one item after a random idle gap; start stays high for a following item.
  task automatic send(req_t rq);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Stops issuing and waits until every result has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_t mk(logic [3:0] op, logic [11:0] idx, logic [63:0] opnd,
                              logic [63:0] expv);
    req_t r;
    r.operation      = op;
    r.elem_index     = idx;
    r.operand_value  = opnd;
    r.expected_value = expv;
    return r;
  endfunction

  // Operand bits: extremes, sign boundaries of each width, small and random words.
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'h80 << (8 * $urandom_range(0, 7));
      3:       w = (64'h80 << (8 * $urandom_range(0, 7))) - 64'd1;
      4:       w = 64'($urandom_range(0, 255));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Random item: mostly in-range hits on a few hot elements so values build up.
  function automatic req_t gen_item(int length);
    req_t r;
    int   top_idx;
    int   pick;
    top_idx = (length > 4096) ? 4095 : length - 1;
    if ($urandom_range(99) < 4)
      r.operation = 4'($urandom_range(OP_CMPXCHG + 1, OP_LAST_CODE));
    else
      r.operation = 4'($urandom_range(OP_LOAD, OP_CMPXCHG));
    pick = $urandom_range(99);
    if (length == 0 || pick >= 85)
      r.elem_index = 12'($urandom_range(0, 4095));
    else if (pick < 55)
      r.elem_index = 12'($urandom_range(0, (top_idx < 15) ? top_idx : 15));
    else
      r.elem_index = 12'($urandom_range(0, top_idx));
    r.operand_value  = rand_word();
    r.expected_value = rand_word();
    // Compare-exchange often expects what was last put there, so swaps happen.
    if (r.operation == OP_CMPXCHG && r.elem_index < 16) begin
      pick = $urandom_range(99);
      if (pick < 50)
        r.expected_value = last_put[r.elem_index];
      else if (pick < 70)
        r.expected_value = '0;
    end
    if ((r.operation == OP_STORE || r.operation == OP_XCHG) && r.elem_index < 16)
      last_put[r.elem_index] = r.operand_value;
    return r;
  endfunction

  initial begin
    logic [2:0]  kind;
    logic [11:0] offset;
    logic [12:0] length;
    int unsigned nbytes;
    int unsigned pct_by_phase [4];

    pct_by_phase = '{0, 76, 0, 19};
    idle_pct   = 0;
    items_sent = 0;
    views      = 0;
    for (int i = 0; i < 16; i++) last_put[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // The view after reset is empty, so any index is out of range.
    send(mk(OP_LOAD, 12'd0, '0, '0));
    settle();

    // Signed bytes starting at the last address, so element one wraps to address zero.
    set_view(KIND_INT8, 12'hFFF, 13'd16);
    send(mk(OP_STORE, 12'd0, 64'hFFFF_FFFF_FFFF_FF80, '0));
    send(mk(OP_LOAD, 12'd0, '0, '1));
    send(mk(OP_ADD, 12'd0, 64'h7F, '0));
    send(mk(OP_SUB, 12'd0, 64'h1, '0));
    send(mk(OP_AND, 12'd0, 64'h0F, '0));
    send(mk(OP_OR, 12'd1, 64'hF0, '0));
    send(mk(OP_XOR, 12'd1, '1, '0));
    send(mk(OP_XCHG, 12'd1, 64'h55, '0));
    // Compare-exchange that matches only after masking, then one that misses.
    send(mk(OP_CMPXCHG, 12'd1, 64'hAA, 64'hFFFF_FFFF_FFFF_FF55));
    send(mk(OP_CMPXCHG, 12'd1, 64'h12, 64'h55));
    send(mk(OP_CMPXCHG + 4'd1, 12'd2, '1, '1));
    send(mk(OP_LAST_CODE, 12'd3, '1, '1));
    send(mk(OP_LOAD, 12'd15, '0, '0));
    send(mk(OP_LOAD, 12'd16, '0, '0));
    send(mk(OP_STORE, 12'hFFF, '1, '1));
    settle();

    // Unaligned 64-bit view covering the whole memory, with wrapping addresses.
    set_view(KIND_UINT64, 12'd4093, 13'd4096);
    send(mk(OP_STORE, 12'd0, '1, '0));
    send(mk(OP_ADD, 12'd0, 64'h1, '0));
    send(mk(OP_LOAD, 12'hFFF, '0, '0));
    send(mk(OP_CMPXCHG, 12'hFFF, 64'h8000_0000_0000_0000, '0));
    send(mk(OP_SUB, 12'hFFF, 64'h1, '0));
    send(mk(OP_LOAD, 12'hFFF, '1, '1));
    settle();

    // Length well past the memory size: only the length bounds the index.
    set_view(KIND_INT16, 12'd1, 13'h1FFF);
    send(mk(OP_LOAD, 12'hFFF, '0, '0));
    send(mk(OP_STORE, 12'hFFF, 64'h8000, '0));
    send(mk(OP_LOAD, 12'hFFF, '0, '0));
    settle();

    // Random phases, each under a fresh view and its own idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      kind   = 3'(p % 8);
      nbytes = 1 << kind[2:1];
      case (p % 4)
        0:       offset = '0;
        1:       offset = 12'hFFF;
        2:       offset = 12'($urandom_range(0, 4095)) & ~12'(nbytes - 1);
        default: offset = 12'($urandom_range(0, 4095));
      endcase
      case (p % 6)
        0:       length = 13'd1;
        1:       length = 13'd8;
        2:       length = 13'd64;
        3:       length = 13'($urandom_range(1, 4096));
        4:       length = 13'd4096;
        default: length = 13'($urandom_range(4097, 8191));
      endcase
      for (int i = 0; i < 16; i++) last_put[i] = '0;
      set_view(kind, offset, length);
      idle_pct = pct_by_phase[p % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, drain the pipeline in the middle of a phase.
        if (p == 5 && n == PHASE_ITEMS / 2)
          settle();
        send(gen_item(int'(length)));
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("tb_top: %0d items over %0d views, all eight kinds, wrapped and unaligned offsets",
             items_sent, views);
    $display("tb_top: %0d results checked, %0d out of range, %0d compare-exchange swaps",
             checked, range_hits, swaps);
    if (failures == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
sv/armu_pkg.sv
sv/atomic_rmw_memory_unit_top.sv
tb/armu_checker.sv
tb/tb_top.sv
